/* rtl/core/ssdw_pkg.sv */
`default_nettype none

package ssdw_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Request commands
    localparam logic [2:0] CMD_INT       = 3'd0;
    localparam logic [2:0] CMD_INT_POINT = 3'd1;
    localparam logic [2:0] CMD_TIME      = 3'd2;
    localparam logic [2:0] CMD_RAW       = 3'd3;
    localparam logic [2:0] CMD_COLON     = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;

    // Digit codes beyond 0..9
    localparam logic [3:0] CODE_SPACE = 4'd10;
    localparam logic [3:0] CODE_MINUS = 4'd11;

    localparam logic [2:0] MAX_DIGITS        = 3'd4;
    localparam logic [2:0] DIGIT_COUNT_RESET = 3'd4;

    localparam logic [2:0] POS_COLON  = 3'd2;
    localparam logic [2:0] SLOT_LAST_DIGIT = 3'd3;
    localparam logic [2:0] SLOT_COLON = 3'd4;

    localparam logic [7:0] COLON_LIT     = 8'h02;
    localparam logic [7:0] RAW_COLON_LIT = 8'hFF;
    localparam logic [7:0] SEG_BLANK     = 8'h00;

    // floor(x / 10) = (x * RECIP_TEN) >> RECIP_TEN_SHIFT for x < 16384
    localparam logic [15:0] RECIP_TEN       = 16'hCCCD;
    localparam int          RECIP_TEN_SHIFT = 19;
    // floor(x / 10) = (x * RECIP_TEN_SMALL) >> 11 for x < 100
    localparam logic [7:0]  RECIP_TEN_SMALL = 8'd205;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] value;
        logic [2:0]         point_position;
        logic [7:0]         left_pair;
        logic [7:0]         right_pair;
        logic [31:0]        raw_segments;
        logic               colon_on;
    } disp_req_t;

    typedef struct packed {
        logic [2:0] position;
        logic       write_needed;
        logic [3:0] register_address;
        logic [7:0] segments;
        logic       last;
        logic       in_range;
    } seg_write_t;

    // One classified request, ready for the writer
    typedef struct packed {
        logic [3:0][7:0] digit_seg;
        logic [7:0]      colon_seg;
        logic            has_digits;
        logic            has_colon;
        logic            in_range;
    } seg_job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_REDUCE,
        FR_DIGIT,
        FR_ISSUE
    } front_state_t;

    function automatic logic [7:0] glyph(input logic [3:0] code);
        logic [7:0] pat;
        case (code)
            4'd0:       pat = 8'h3F;
            4'd1:       pat = 8'h06;
            4'd2:       pat = 8'h5B;
            4'd3:       pat = 8'h4F;
            4'd4:       pat = 8'h66;
            4'd5:       pat = 8'h6D;
            4'd6:       pat = 8'h7D;
            4'd7:       pat = 8'h07;
            4'd8:       pat = 8'h7F;
            4'd9:       pat = 8'h6F;
            CODE_MINUS: pat = 8'h40;
            default:    pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

    function automatic logic [2:0] digit_position(input logic [1:0] slot);
        logic [2:0] pos;
        case (slot)
            2'd0:    pos = 3'd0;
            2'd1:    pos = 3'd1;
            2'd2:    pos = 3'd3;
            default: pos = 3'd4;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ssdw_front.sv */
`default_nettype none

module ssdw_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  ssdw_pkg::disp_req_t       s_data,
    input  wire logic [2:0]           digit_count,
    output logic                      job_push,
    output ssdw_pkg::seg_job_t        job,
    input  wire logic                 queue_full
);
    import ssdw_pkg::*;

    front_state_t state_reg, state_next;
    logic [1:0]   step_reg, step_next;

    disp_req_t       req_reg;
    logic            neg_reg;
    logic [15:0]     mag_reg;
    logic            inr_reg;
    logic [13:0]     x_reg;
    logic [6:0]      lmod_reg, rmod_reg;
    logic [3:0][3:0] digit_reg;

    logic        accept;
    logic        is_int;
    logic        is_time;
    logic        job_ok;
    logic        issue_done;

    logic        in_neg;
    logic [15:0] in_mag;
    logic        in_inr;

    logic [15:0] rem;
    logic [6:0]  lmod, rmod;

    logic [29:0] prod;
    logic [10:0] quot;
    logic [13:0] quot_ten;
    logic [13:0] dig_wide;
    logic [14:0] lprod, rprod;
    logic [3:0]  ltens, rtens;
    logic [6:0]  lones, rones;

    logic [2:0]  shown;
    logic [2:0]  lim;

    assign is_int  = (req_reg.command == CMD_INT) || (req_reg.command == CMD_INT_POINT);
    assign is_time = (req_reg.command == CMD_TIME);
    assign job_ok  = (req_reg.command <= CMD_CLEAR);

    assign issue_done = (state_reg == FR_ISSUE) && (!queue_full || !job_ok);
    assign s_ready    = (state_reg == FR_IDLE) || issue_done;
    assign accept     = s_valid && s_ready;
    assign job_push   = (state_reg == FR_ISSUE) && job_ok && !queue_full;

    // Accept-time classification
    always_comb begin
        in_neg = s_data.value[15];
        in_mag = in_neg ? 16'(~s_data.value + 16'd1) : s_data.value;
        case (s_data.command)
            CMD_INT, CMD_INT_POINT: begin
                in_inr = ($signed(s_data.value) > -16'sd1000) &&
                         ($signed(s_data.value) < 16'sd10000);
            end
            CMD_TIME: begin
                in_inr = (s_data.left_pair < 8'd100) && (s_data.right_pair < 8'd100);
            end
            default: begin
                in_inr = 1'b1;
            end
        endcase
    end

    // Magnitude mod 10000 and pairs mod 100
    always_comb begin
        if (mag_reg >= 16'd30000) begin
            rem = mag_reg - 16'd30000;
        end else if (mag_reg >= 16'd20000) begin
            rem = mag_reg - 16'd20000;
        end else if (mag_reg >= 16'd10000) begin
            rem = mag_reg - 16'd10000;
        end else begin
            rem = mag_reg;
        end
        if (req_reg.left_pair >= 8'd200) begin
            lmod = 7'(req_reg.left_pair - 8'd200);
        end else if (req_reg.left_pair >= 8'd100) begin
            lmod = 7'(req_reg.left_pair - 8'd100);
        end else begin
            lmod = 7'(req_reg.left_pair);
        end
        if (req_reg.right_pair >= 8'd200) begin
            rmod = 7'(req_reg.right_pair - 8'd200);
        end else if (req_reg.right_pair >= 8'd100) begin
            rmod = 7'(req_reg.right_pair - 8'd100);
        end else begin
            rmod = 7'(req_reg.right_pair);
        end
    end

    // One digit per divide step (two on the last); pairs split into tens/ones
    assign prod     = 30'(x_reg) * 30'(RECIP_TEN);
    assign quot     = prod[29:RECIP_TEN_SHIFT];
    assign quot_ten = 14'(quot) * 14'd10;
    assign dig_wide = x_reg - quot_ten;

    assign lprod = 15'(lmod_reg) * 15'(RECIP_TEN_SMALL);
    assign rprod = 15'(rmod_reg) * 15'(RECIP_TEN_SMALL);
    assign ltens = lprod[14:11];
    assign rtens = rprod[14:11];
    assign lones = lmod_reg - 7'(7'(ltens) * 7'd10);
    assign rones = rmod_reg - 7'(7'(rtens) * 7'd10);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    state_next = FR_REDUCE;
                end
            end
            FR_REDUCE: begin
                step_next = 2'd0;
                if (is_int || is_time) begin
                    state_next = FR_DIGIT;
                end else begin
                    state_next = FR_ISSUE;
                end
            end
            FR_DIGIT: begin
                step_next = step_reg + 2'd1;
                if (is_int && (step_reg != 2'd2)) begin
                    state_next = FR_DIGIT;
                end else begin
                    state_next = FR_ISSUE;
                end
            end
            FR_ISSUE: begin
                if (issue_done) begin
                    state_next = accept ? FR_REDUCE : FR_IDLE;
                end
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
            neg_reg <= in_neg;
            mag_reg <= in_mag;
            inr_reg <= in_inr;
        end
        if (state_reg == FR_REDUCE) begin
            x_reg    <= rem[13:0];
            lmod_reg <= lmod;
            rmod_reg <= rmod;
        end
        if (state_reg == FR_DIGIT) begin
            if (is_int) begin
                digit_reg[2'd3 - step_reg] <= dig_wide[3:0];
                x_reg                      <= 14'(quot);
                if (step_reg == 2'd2) begin
                    digit_reg[0] <= quot[3:0];
                end
            end else begin
                digit_reg[0] <= ltens;
                digit_reg[1] <= lones[3:0];
                digit_reg[2] <= rtens;
                digit_reg[3] <= rones[3:0];
            end
        end
    end

    // Build the patterns of the classified request
    always_comb begin
        logic [3:0][3:0] codes;
        logic            run;
        logic [2:0]      nblank;
        logic [1:0]      minus_at;
        logic [7:0]      gpat;

        shown    = (digit_count > MAX_DIGITS) ? MAX_DIGITS : digit_count;
        lim      = MAX_DIGITS - shown;
        codes    = digit_reg;
        run      = 1'b1;
        nblank   = 3'd0;
        minus_at = 2'd0;
        gpat     = SEG_BLANK;

        if (is_int && neg_reg) begin
            if (shown >= 3'd3) begin
                codes[0] = CODE_MINUS;
            end else begin
                run    = 1'b1;
                nblank = 3'd0;
                for (int i = 0; i < 4; i++) begin
                    if (run && (3'(i) < lim) && (codes[i] == 4'd0)) begin
                        codes[i] = CODE_SPACE;
                        nblank   = nblank + 3'd1;
                    end else begin
                        run = 1'b0;
                    end
                end
                // minus takes the last blank, or digit 0 when nothing blanked
                minus_at = (nblank == 3'd0) ? 2'd0 : 2'(nblank - 3'd1);
                codes[minus_at] = CODE_MINUS;
            end
        end

        if ((req_reg.command == CMD_INT) || is_time) begin
            run = 1'b1;
            for (int i = 0; i < 4; i++) begin
                if (run && (3'(i) < lim) && (codes[i] == 4'd0)) begin
                    codes[i] = CODE_SPACE;
                end else begin
                    run = 1'b0;
                end
            end
        end

        job.in_range   = inr_reg;
        job.has_digits = (req_reg.command != CMD_COLON);
        job.has_colon  = req_reg.command inside {CMD_TIME, CMD_RAW, CMD_COLON, CMD_CLEAR};

        for (int i = 0; i < 4; i++) begin
            gpat = glyph(codes[i]);
            case (req_reg.command)
                CMD_RAW: begin
                    job.digit_seg[i] = req_reg.raw_segments[8*i +: 8];
                end
                CMD_CLEAR: begin
                    job.digit_seg[i] = SEG_BLANK;
                end
                CMD_INT_POINT: begin
                    job.digit_seg[i] = {req_reg.point_position == 3'(i), gpat[6:0]};
                end
                default: begin
                    job.digit_seg[i] = gpat;
                end
            endcase
        end

        case (req_reg.command)
            CMD_TIME, CMD_COLON: begin
                job.colon_seg = req_reg.colon_on ? COLON_LIT : SEG_BLANK;
            end
            CMD_RAW: begin
                job.colon_seg = req_reg.colon_on ? RAW_COLON_LIT : SEG_BLANK;
            end
            default: begin
                job.colon_seg = SEG_BLANK;
            end
        endcase
    end

    ast_digit_only_numeric: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FR_DIGIT) |-> (is_int || is_time))
        else $error("digit step on a command without digits");

    ast_time_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FR_DIGIT) && is_time |=> (state_reg == FR_ISSUE))
        else $error("time request spent more than one digit step");

    ast_int_three_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FR_ISSUE) && is_int && $past(state_reg == FR_DIGIT)
            |-> $past(step_reg == 2'd2))
        else $error("integer request left the digit loop early");

endmodule

`default_nettype wire

/* rtl/core/ssdw_queue.sv */
`default_nettype none

module ssdw_queue #(
    parameter int DEPTH = ssdw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  ssdw_pkg::seg_job_t   push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output ssdw_pkg::seg_job_t   head
);
    import ssdw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seg_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    ast_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");

    ast_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    ast_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* rtl/core/ssdw_back.sv */
`default_nettype none

module ssdw_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  ssdw_pkg::seg_job_t    head,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ssdw_pkg::seg_write_t  m_data
);
    import ssdw_pkg::*;

    logic       busy_reg, busy_next;
    logic [2:0] slot_reg, slot_next;
    logic       m_valid_reg, m_valid_next;
    seg_job_t   job_reg;
    seg_write_t m_data_reg;
    logic [7:0] cache_reg [5];
    logic [4:0] cache_valid_reg;

    logic       out_free;
    logic       emit;
    logic       emit_last;
    logic [2:0] emit_pos;
    logic [7:0] emit_seg;
    logic       emit_need;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_free;

    always_comb begin
        if (slot_reg == SLOT_COLON) begin
            emit_pos = POS_COLON;
            emit_seg = job_reg.colon_seg;
        end else begin
            emit_pos = digit_position(slot_reg[1:0]);
            emit_seg = job_reg.digit_seg[slot_reg[1:0]];
        end
        emit_last = (slot_reg == SLOT_COLON) ||
                    ((slot_reg == SLOT_LAST_DIGIT) && !job_reg.has_colon);
        emit_need = !cache_valid_reg[emit_pos] || (cache_reg[emit_pos] != emit_seg);
    end

    // Take the next job when idle or while the last word of this one goes out
    assign pop = head_valid && (!busy_reg || (emit && emit_last));

    always_comb begin
        busy_next    = busy_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            if (emit_last) begin
                busy_next = 1'b0;
            end else if (slot_reg == SLOT_LAST_DIGIT) begin
                slot_next = SLOT_COLON;
            end else begin
                slot_next = slot_reg + 3'd1;
            end
        end
        if (pop) begin
            busy_next = 1'b1;
            slot_next = head.has_digits ? 3'd0 : SLOT_COLON;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            slot_reg        <= 3'd0;
            m_valid_reg     <= 1'b0;
            cache_valid_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
            if (emit) begin
                cache_valid_reg[emit_pos] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head;
        end
        if (emit) begin
            cache_reg[emit_pos]         <= emit_seg;
            m_data_reg.position         <= emit_pos;
            m_data_reg.write_needed     <= emit_need;
            m_data_reg.register_address <= {emit_pos, 1'b0};
            m_data_reg.segments         <= emit_seg;
            m_data_reg.last             <= emit_last;
            m_data_reg.in_range         <= job_reg.in_range;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ast_stay_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !emit_last |=> busy_reg)
        else $error("job dropped before its last word");

    ast_cache_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> cache_valid_reg[$past(emit_pos)])
        else $error("written position not marked in cache");

    ast_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (slot_reg <= SLOT_COLON))
        else $error("slot beyond the colon position");

endmodule

`default_nettype wire

/* rtl/core/seven_segment_display_writer.sv */
`default_nettype none

// Display writer for a four-digit seven-segment display with a colon.
// Input channel s_valid/s_ready/s_data carries one request word: integer,
// integer with point, time, raw patterns, colon only or clear. The result
// channel m_valid/m_ready/m_data carries one word per touched position
// (digits 0,1,3,4, then the colon), with write_needed set where the pattern
// differs from the cached one; last marks the final word of a request.
// cfg_wr_en/cfg_wr_data set the digit count; write it only while idle.
// From acceptance a request passes the classifier states reduce, digit
// (integer and time only) and issue, then the job queue, then the output
// register. The output port sends one word per cycle while the receiver
// takes each word; a request takes 4 or 5 words, 1 for colon only. The
// classifier spends one reduction, three divide-by-ten steps and issue on an
// integer request, one digit step on a time request and none otherwise, and
// takes a new request only as it issues the last one. A small job queue sits between classifier and writer.
// Reset empties the queue, invalidates the pattern cache (so the first
// write to each position is always flagged) and sets the digit count to 4.
// When the receiver stalls, the output word holds, the queue fills and
// s_ready drops; nothing is lost.
module seven_segment_display_writer #(
    parameter int QUEUE_DEPTH = ssdw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  ssdw_pkg::disp_req_t   s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ssdw_pkg::seg_write_t  m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_wr_data
);
    import ssdw_pkg::*;

    logic [2:0] digit_count_reg;

    logic       job_push;
    seg_job_t   job;
    logic       queue_full;
    logic       job_pop;
    logic       head_valid;
    seg_job_t   head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= DIGIT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            digit_count_reg <= cfg_wr_data;
        end
    end

    ssdw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .digit_count (digit_count_reg),
        .job_push    (job_push),
        .job         (job),
        .queue_full  (queue_full)
    );

    ssdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_data  (job),
        .full       (queue_full),
        .pop        (job_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ssdw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (job_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
